// ===== design/delta_regression_coefficients_top_assert.svh =====
// assertion macros for the delta regression block
// depends on clk and rst_n being visible where a macro is used
`ifndef DELTA_REGRESSION_COEFFICIENTS_TOP_ASSERT_SVH
`define DELTA_REGRESSION_COEFFICIENTS_TOP_ASSERT_SVH

// condition must hold at every edge outside reset
`define DRC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define DRC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/drc_pkg.sv =====
// shared types and constants for the delta regression block
// no dependencies
`timescale 1ns / 1ps

package drc_pkg;

  // default sizes
  localparam int DEF_MAX_WIN   = 4;
  localparam int DEF_MAX_BASE  = 16;
  localparam int DEF_MAX_ORDER = 3;

  // register reset values
  localparam logic [2:0] RST_WINDOW   = 3'd2;
  localparam logic [1:0] RST_ORDER    = 2'd1;
  localparam logic [4:0] RST_BASE_LEN = 5'd13;

  // counters that saturate at seven
  localparam logic [2:0] CNT_SAT = 3'd7;

  // register indexes
  typedef enum logic [1:0] {
    REG_WINDOW   = 2'd0,
    REG_ORDER    = 2'd1,
    REG_BASE_LEN = 2'd2
  } cfg_reg_t;

  // input kinds
  localparam logic ACT_VALUE = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // sequencer states
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_ZFILL = 11'b00000000010,
    S_CRD   = 11'b00000000100,
    S_CWAIT = 11'b00000001000,
    S_DRDN  = 11'b00000010000,
    S_DRDO  = 11'b00000100000,
    S_DACC  = 11'b00001000000,
    S_DPREP = 11'b00010000000,
    S_DIV   = 11'b00100000000,
    S_DFIX  = 11'b01000000000,
    S_DOUT  = 11'b10000000000
  } state_t;

endpackage

// ===== design/drc_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module drc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 432
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/delta_regression_coefficients_top.sv =====
// delta regression coefficients: frame store, copy and delta sequencer
// depends on drc_pkg, drc_ram and delta_regression_coefficients_top_assert.svh
//
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/in_tready  | tdata sample, tuser action, tlast frame_end
// out_    | out | out_tvalid/out_tready| tdata coeff, tuser is_delta, tlast last
// cfg_    | in  | cfg_valid/cfg_ready  | cfg_index register, cfg_data value
//
// a frame end zero-fills the rest of the frame slot before the frame is committed.
// emitted copies and deltas are paced by the single memory read port and the
// reciprocal divide with its correction step.
// synchronous active-low reset clears control state; the store needs none.
// a stalled output holds the sequencer; input is taken only when idle.
`timescale 1ns / 1ps

module delta_regression_coefficients_top #(
  parameter int MAX_WIN   = drc_pkg::DEF_MAX_WIN,
  parameter int MAX_BASE  = drc_pkg::DEF_MAX_BASE,
  parameter int MAX_ORDER = drc_pkg::DEF_MAX_ORDER
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic        in_tuser,   // [0] action
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] coeff
  output logic        out_tuser,  // [0] is_delta
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  import drc_pkg::*;

  localparam int NSLOT  = 2 * MAX_WIN + 1;
  localparam int STRIDE = MAX_ORDER * MAX_BASE;
  localparam int DEPTH  = NSLOT * STRIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int SW     = $clog2(NSLOT);
  localparam int EW     = $clog2(STRIDE + 1);
  localparam int WW     = $clog2(MAX_WIN + 1);
  localparam int BW     = $clog2(MAX_BASE + 1);
  localparam int OFW    = $clog2(NSLOT + 15);
  localparam int ACCW   = 18 + $clog2(MAX_WIN * (MAX_WIN + 1) / 2 + 1);
  localparam int NUMW   = ACCW + 1;
  localparam int SQW    = $clog2(MAX_WIN * (MAX_WIN + 1) * (2 * MAX_WIN + 1) / 6 + 1);
  localparam int DVW    = SQW + 1;

  // configuration registers
  logic [2:0] window_r;
  logic [1:0] order_r;
  logic [4:0] base_len_r;

  // control state
  state_t           state_r, state_nxt;
  logic [SW-1:0]    newest_r, newest_nxt;
  logic [EW-1:0]    eidx_r, eidx_nxt;
  logic [EW-1:0]    zidx_r, zidx_nxt;
  logic [2:0]       pending_r, pending_nxt;
  logic [2:0]       seen_r, seen_nxt;
  logic [2:0]       centre_r, centre_nxt;
  logic             flush_r, flush_nxt;
  logic [EW-1:0]    cnt_r, cnt_nxt;
  logic [BW-1:0]    didx_r, didx_nxt;
  logic [WW-1:0]    j_r, j_nxt;
  logic signed [ACCW-1:0] acc_r, acc_nxt;
  logic [SQW-1:0]   sq_r, sq_nxt;
  logic signed [16:0] newv_r, newv_nxt;
  logic [NUMW-1:0]  num_r, num_nxt;
  logic [NUMW-1:0]  quo_r, quo_nxt;
  logic             neg_r, neg_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_data_r, out_data_nxt;
  logic        out_user_r, out_user_nxt;
  logic        out_last_r, out_last_nxt;

  // memory port signals
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;
  logic [EW-1:0] widx, ridx;
  logic [OFW-1:0] rofs;

  // effective register values
  logic [WW-1:0] weff;
  logic [BW-1:0] beff;
  logic [1:0]    oeff;
  logic [EW-1:0] len, dbase;

  always_comb begin
    if (window_r == 3'd0) weff = WW'(1);
    else if (32'(window_r) > MAX_WIN) weff = WW'(MAX_WIN);
    else weff = WW'(window_r);
    if (base_len_r == 5'd0) beff = BW'(1);
    else if (32'(base_len_r) > MAX_BASE) beff = BW'(MAX_BASE);
    else beff = BW'(base_len_r);
    if (order_r == 2'd0) oeff = 2'd1;
    else if (32'(order_r) > MAX_ORDER) oeff = 2'(MAX_ORDER);
    else oeff = order_r;
    len   = EW'(oeff * beff);
    dbase = EW'((oeff - 2'd1) * beff);
  end

  // slot after the newest, where the incoming frame goes
  logic [SW-1:0] wslot;
  always_comb begin
    if (32'(newest_r) == NSLOT - 1) wslot = '0;
    else wslot = newest_r + SW'(1);
  end

  // slot that lies a given number of frames behind the newest
  logic [SW-1:0] ofs_cl;
  logic [SW:0]   slot_t;
  logic [SW-1:0] rslot;
  always_comb begin
    if (32'(rofs) > NSLOT - 1) ofs_cl = SW'(NSLOT - 1);
    else ofs_cl = SW'(rofs);
    slot_t = {1'b0, newest_r} + (SW + 1)'(NSLOT) - {1'b0, ofs_cl};
    if (32'(slot_t) >= NSLOT) rslot = SW'(slot_t - (SW + 1)'(NSLOT));
    else rslot = SW'(slot_t);
  end

  // read offset and element by state
  logic [OFW-1:0] nofs, oofs;
  always_comb begin
    if (32'(centre_r) >= 32'(j_r)) nofs = OFW'(centre_r) - OFW'(j_r);
    else nofs = '0;
    if (32'(j_r) < 32'(seen_r)) oofs = OFW'(centre_r) + OFW'(j_r);
    else oofs = OFW'(centre_r) + OFW'(seen_r);
    if (state_r == S_DRDN) rofs = nofs;
    else if (state_r == S_DRDO) rofs = oofs;
    else rofs = OFW'(centre_r);
    if (state_r == S_CRD) ridx = cnt_r;
    else ridx = dbase + EW'(didx_r);
  end

  assign ram_raddr = AW'(rslot) * AW'(STRIDE) + AW'(ridx);
  assign ram_re    = (state_r == S_CRD) || (state_r == S_DRDN) || (state_r == S_DRDO);

  // writes: incoming sample or zero fill of the frame tail
  logic in_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    if (state_r == S_ZFILL) begin
      widx      = zidx_r;
      ram_wdata = '0;
      ram_we    = (32'(zidx_r) < STRIDE);
    end else begin
      widx      = eidx_r;
      ram_wdata = in_tdata;
      ram_we    = in_acc && (in_tuser == ACT_VALUE) && (eidx_r < len);
    end
  end
  assign ram_waddr = AW'(wslot) * AW'(STRIDE) + AW'(widx);

  drc_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // datapath helpers
  logic               out_free;
  logic signed [16:0] diff;
  logic signed [ACCW-1:0] prod;
  logic [ACCW-1:0]    mag;
  logic [DVW-1:0]     dvs;
  logic [16:0]        qsat;
  logic [16:0]        qsgn;
  logic [2:0]         pend_inc;
  logic [NUMW-1:0]    recip;
  logic [2*NUMW-1:0]  qprod;
  logic [NUMW-1:0]    qback;
  logic [NUMW-1:0]    rem_fix;

  assign out_free = !out_valid_r || out_tready;
  assign diff     = newv_r - {ram_rdata[15], ram_rdata};
  assign prod     = ACCW'($signed({1'b0, j_r}) * diff);
  assign mag      = acc_r[ACCW-1] ? ACCW'(-acc_r) : ACCW'(acc_r);
  assign dvs      = {sq_r, 1'b0};
  assign pend_inc = (pending_r == CNT_SAT) ? pending_r : pending_r + 3'd1;

  // reciprocal of twice the window norm, one table entry per window
  always_comb begin
    recip = '0;
    for (int k = 1; k <= MAX_WIN; k++) begin
      if (32'(weff) == k) begin
        recip = NUMW'((64'd1 << NUMW) / 64'(k * (k + 1) * (2 * k + 1) / 3));
      end
    end
  end

  // quotient estimate and its remainder
  assign qprod   = num_r * recip;
  assign qback   = NUMW'(quo_r * dvs);
  assign rem_fix = num_r - qback;

  always_comb begin
    if (neg_r) qsat = (quo_r > NUMW'(32768)) ? 17'd32768 : 17'(quo_r);
    else qsat = (quo_r > NUMW'(32767)) ? 17'd32767 : 17'(quo_r);
    qsgn = neg_r ? -qsat : qsat;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    newest_nxt    = newest_r;
    eidx_nxt      = eidx_r;
    zidx_nxt      = zidx_r;
    pending_nxt   = pending_r;
    seen_nxt      = seen_r;
    centre_nxt    = centre_r;
    flush_nxt     = flush_r;
    cnt_nxt       = cnt_r;
    didx_nxt      = didx_r;
    j_nxt         = j_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    newv_nxt      = newv_r;
    num_nxt       = num_r;
    quo_nxt       = quo_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == ACT_FLUSH) begin
            eidx_nxt = '0;
            if (pending_r != 3'd0) begin
              flush_nxt  = 1'b1;
              centre_nxt = pending_r - 3'd1;
              cnt_nxt    = '0;
              state_nxt  = S_CRD;
            end
          end else begin
            // store the value, then pad the slot on a frame end
            logic [EW-1:0] e_after;
            e_after = (eidx_r < len) ? eidx_r + EW'(1) : eidx_r;
            eidx_nxt = e_after;
            if (in_tlast) begin
              zidx_nxt  = e_after;
              state_nxt = S_ZFILL;
            end
          end
        end
      end
      S_ZFILL: begin
        if (32'(zidx_r) < STRIDE) begin
          zidx_nxt = zidx_r + EW'(1);
        end else begin
          // commit the frame
          newest_nxt  = wslot;
          eidx_nxt    = '0;
          pending_nxt = pend_inc;
          if (32'(pend_inc) > 32'(weff)) begin
            flush_nxt  = 1'b0;
            centre_nxt = pend_inc - 3'd1;
            cnt_nxt    = '0;
            state_nxt  = S_CRD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CRD: begin
        state_nxt = S_CWAIT;
      end
      S_CWAIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = ram_rdata;
          out_user_nxt  = 1'b0;
          out_last_nxt  = 1'b0;
          if (cnt_r == len - EW'(1)) begin
            didx_nxt  = '0;
            j_nxt     = WW'(1);
            acc_nxt   = '0;
            sq_nxt    = '0;
            state_nxt = S_DRDN;
          end else begin
            cnt_nxt   = cnt_r + EW'(1);
            state_nxt = S_CRD;
          end
        end
      end
      S_DRDN: begin
        state_nxt = S_DRDO;
      end
      S_DRDO: begin
        newv_nxt  = {ram_rdata[15], ram_rdata};
        state_nxt = S_DACC;
      end
      S_DACC: begin
        acc_nxt = acc_r + prod;
        sq_nxt  = sq_r + SQW'(j_r * j_r);
        if (j_r == weff) begin
          state_nxt = S_DPREP;
        end else begin
          j_nxt     = j_r + WW'(1);
          state_nxt = S_DRDN;
        end
      end
      S_DPREP: begin
        // rounded magnitude: (|acc| + norm) / (2*norm)
        num_nxt   = NUMW'(mag) + NUMW'(sq_r);
        neg_nxt   = acc_r[ACCW-1];
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // reciprocal multiply, exact or one low
        quo_nxt   = qprod[2*NUMW-1:NUMW];
        state_nxt = S_DFIX;
      end
      S_DFIX: begin
        // one correction step on the remainder
        if (rem_fix >= NUMW'(dvs)) quo_nxt = quo_r + NUMW'(1);
        state_nxt = S_DOUT;
      end
      S_DOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = qsgn[15:0];
          out_user_nxt  = 1'b1;
          out_last_nxt  = (didx_r == beff - BW'(1));
          if (didx_r == beff - BW'(1)) begin
            // frame done
            pending_nxt = pending_r - 3'd1;
            if (flush_r && pending_r == 3'd1) seen_nxt = '0;
            else if (seen_r != CNT_SAT) seen_nxt = seen_r + 3'd1;
            state_nxt = S_IDLE;
          end else begin
            didx_nxt  = didx_r + BW'(1);
            j_nxt     = WW'(1);
            acc_nxt   = '0;
            sq_nxt    = '0;
            state_nxt = S_DRDN;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      newest_r    <= '0;
      eidx_r      <= '0;
      pending_r   <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      newest_r    <= newest_nxt;
      eidx_r      <= eidx_nxt;
      pending_r   <= pending_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    zidx_r     <= zidx_nxt;
    centre_r   <= centre_nxt;
    flush_r    <= flush_nxt;
    cnt_r      <= cnt_nxt;
    didx_r     <= didx_nxt;
    j_r        <= j_nxt;
    acc_r      <= acc_nxt;
    sq_r       <= sq_nxt;
    newv_r     <= newv_nxt;
    num_r      <= num_nxt;
    quo_r      <= quo_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  // configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= RST_WINDOW;
      order_r    <= RST_ORDER;
      base_len_r <= RST_BASE_LEN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW:   window_r   <= cfg_data[2:0];
        REG_ORDER:    order_r    <= cfg_data[1:0];
        REG_BASE_LEN: base_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // checks
  `include "delta_regression_coefficients_top_assert.svh"

  `DRC_ASSERT_IMPLY(a_last_on_delta, out_tvalid && out_tlast, out_tuser,
    "frame end marked on a copied value")
  `DRC_ASSERT_IMPLY(a_no_write_in_emit, state_r != S_IDLE && state_r != S_ZFILL,
    !ram_we, "store written while a frame is emitted")
  `DRC_ASSERT_IMPLY(a_emit_has_pending, state_r == S_CRD, pending_r != 3'd0,
    "frame emitted with nothing pending")

endmodule

// ===== tb/sv/tb_delta_regression_coefficients_top.sv =====
// self-checking testbench for the delta regression coefficients block
// depends on drc_pkg and delta_regression_coefficients_top
`timescale 1ns / 1ps

module tb_delta_regression_coefficients_top;
  import drc_pkg::*;

  localparam int SLOTS     = 2 * DEF_MAX_WIN + 1;
  localparam int SLOT_SIZE = DEF_MAX_ORDER * DEF_MAX_BASE;
  localparam int TARGET_ITEMS = 350;
  localparam int IDLE_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 120;

  typedef struct packed {
    logic [15:0] coeff;
    logic        is_delta;
    logic        last;
  } coeff_result_t;

  // predicts emitted frames and deltas, holds them until the block delivers
  class delta_scoreboard;
    logic signed [15:0] frames [SLOTS][SLOT_SIZE];
    int newest;
    int fill_pos;
    int pending_frames;
    int emitted_frames;
    int win_reg;
    int ord_reg;
    int base_reg;
    int errors;
    coeff_result_t awaited[$];

    function new();
      foreach (frames[s, e]) frames[s][e] = '0;
      newest = 0;
      fill_pos = 0;
      pending_frames = 0;
      emitted_frames = 0;
      win_reg = RST_WINDOW;
      ord_reg = RST_ORDER;
      base_reg = RST_BASE_LEN;
      errors = 0;
    endfunction

    function int win_eff();
      return win_reg < 1 ? 1 : (win_reg > DEF_MAX_WIN ? DEF_MAX_WIN : win_reg);
    endfunction

    function int ord_eff();
      return ord_reg < 1 ? 1 : (ord_reg > DEF_MAX_ORDER ? DEF_MAX_ORDER : ord_reg);
    endfunction

    function int base_eff();
      return base_reg < 1 ? 1 : (base_reg > DEF_MAX_BASE ? DEF_MAX_BASE : base_reg);
    endfunction

    function void write_reg(cfg_reg_t idx, logic [4:0] val);
      case (idx)
        REG_WINDOW:   win_reg = val[2:0];
        REG_ORDER:    ord_reg = val[1:0];
        REG_BASE_LEN: base_reg = val;
        default: ;
      endcase
    endfunction

    function longint frame_value(int ofs, int e);
      int slot;
      if (ofs > SLOTS - 1) ofs = SLOTS - 1;
      slot = (newest + SLOTS - ofs) % SLOTS;
      return longint'(frames[slot][e % SLOT_SIZE]);
    endfunction

    // oldest pending frame: copies, then deltas of its last base block
    function void emit_oldest();
      int w, b, o, ctr, e, nofs, oofs;
      longint den, acc, mag, q;
      coeff_result_t r;
      w = win_eff();
      b = base_eff();
      o = ord_eff();
      ctr = pending_frames - 1;
      den = w * (w + 1) * (2 * w + 1) / 3;
      for (int k = 0; k < o * b; k++) begin
        r.coeff = 16'(frame_value(ctr, k));
        r.is_delta = 1'b0;
        r.last = 1'b0;
        awaited.push_back(r);
      end
      for (int i = 0; i < b; i++) begin
        acc = 0;
        e = (o - 1) * b + i;
        for (int j = 1; j <= w; j++) begin
          nofs = ctr >= j ? ctr - j : 0;
          oofs = ctr + (j < emitted_frames ? j : emitted_frames);
          acc += j * (frame_value(nofs, e) - frame_value(oofs, e));
        end
        mag = acc < 0 ? -acc : acc;
        q = (2 * mag + den) / (2 * den);
        if (acc < 0) q = -q;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        r.coeff = q[15:0];
        r.is_delta = 1'b1;
        r.last = (i + 1 == b);
        awaited.push_back(r);
      end
      pending_frames--;
      if (emitted_frames < CNT_SAT) emitted_frames++;
    endfunction

    function void note_input(logic act, logic [15:0] smp, logic fend);
      int wslot;
      wslot = (newest + 1) % SLOTS;
      if (act == ACT_FLUSH) begin
        fill_pos = 0;
        if (pending_frames > 0) begin
          emit_oldest();
          if (pending_frames == 0) emitted_frames = 0;
        end
        return;
      end
      if (fill_pos < ord_eff() * base_eff()) begin
        frames[wslot][fill_pos] = smp;
        fill_pos++;
      end
      if (fend) begin
        for (int e = fill_pos; e < SLOT_SIZE; e++) frames[wslot][e] = '0;
        newest = wslot;
        fill_pos = 0;
        if (pending_frames < CNT_SAT) pending_frames++;
        if (pending_frames > win_eff()) emit_oldest();
      end
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(coeff_result_t got);
      coeff_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result coeff=%0d is_delta=%0b last=%0b",
                         $signed(got.coeff), got.is_delta, got.last));
        return;
      end
      want = awaited.pop_front();
      if (got.coeff !== want.coeff)
        report($sformatf("coeff got %0d want %0d", $signed(got.coeff), $signed(want.coeff)));
      if (got.is_delta !== want.is_delta)
        report($sformatf("is_delta got %0b want %0b", got.is_delta, want.is_delta));
      if (got.last !== want.last)
        report($sformatf("last got %0b want %0b", got.last, want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;

  delta_scoreboard sb = new();
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int mode_left = 0;

  always #6 clk = ~clk;

  delta_regression_coefficients_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // receiver: checks results and stalls on its own changing pattern
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result('{coeff: out_tdata, is_delta: out_tuser, last: out_tlast});
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(10, 80);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 1) != 0);
      default: out_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // register write; the next input request drops cfg_valid
  task write_reg(cfg_reg_t idx, logic [4:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    sb.write_reg(idx, val);
  endtask

  // one request on the input channel, with bursts and gaps
  task send_item(logic act, logic [15:0] smp, logic fend);
    cfg_valid <= 1'b0;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= smp;
    in_tlast <= fend;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    sb.note_input(act, smp, fend);
    items_sent++;
  endtask

  task wait_idle();
    in_tvalid <= 1'b0;
    while (sb.awaited.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // one frame: normal, short, long or cut off by a flush tick
  task send_frame(int len);
    int kind, n;
    kind = $urandom_range(0, 9);
    n = kind == 0 ? $urandom_range(1, len) : (kind == 1 ? len + $urandom_range(1, 3) : len);
    if (kind == 2) begin
      for (int k = 0; k < $urandom_range(1, len); k++) send_item(ACT_VALUE, rand_sample(), 1'b0);
      send_item(ACT_FLUSH, 16'($urandom()), 1'($urandom()));
      n = len;
    end
    for (int k = 0; k < n; k++) send_item(ACT_VALUE, rand_sample(), k == n - 1);
  endtask

  initial begin
    int nframes, flen;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: window 1 with full-scale swings saturates the deltas
    write_reg(REG_WINDOW, 5'd1);
    write_reg(REG_ORDER, 5'd1);
    write_reg(REG_BASE_LEN, 5'd2);
    send_item(ACT_VALUE, 16'h7fff, 1'b0);
    send_item(ACT_VALUE, 16'h8000, 1'b1);
    send_item(ACT_VALUE, 16'h8000, 1'b0);
    send_item(ACT_VALUE, 16'h7fff, 1'b1);
    send_item(ACT_VALUE, 16'h7fff, 1'b0);
    send_item(ACT_VALUE, 16'h8000, 1'b1);
    // short frame, long frame, partial frame abandoned by a flush tick
    send_item(ACT_VALUE, 16'h1234, 1'b1);
    send_item(ACT_VALUE, 16'hffff, 1'b0);
    send_item(ACT_VALUE, 16'h0001, 1'b0);
    send_item(ACT_VALUE, 16'h5555, 1'b1);
    send_item(ACT_VALUE, 16'haaaa, 1'b0);
    for (int k = 0; k < 5; k++) send_item(ACT_FLUSH, 16'hffff, 1'b1);
    send_item(ACT_FLUSH, 16'h0000, 1'b0);
    wait_idle();

    // random phases, each after optional random register writes
    while (items_sent < TARGET_ITEMS) begin
      if ($urandom_range(0, 1)) write_reg(REG_WINDOW, 5'($urandom_range(0, 7)));
      if ($urandom_range(0, 1)) write_reg(REG_ORDER, 5'($urandom_range(0, 3)));
      if ($urandom_range(0, 1))
        write_reg(REG_BASE_LEN, $urandom_range(0, 4) == 0 ? 5'($urandom_range(0, 31))
                                                          : 5'($urandom_range(0, 5)));
      flen = sb.ord_eff() * sb.base_eff();
      nframes = $urandom_range(1, 9);
      for (int f = 0; f < nframes; f++) send_frame(flen);
      if ($urandom_range(0, 3) != 0)
        for (int k = 0; k <= sb.pending_frames; k++)
          send_item(ACT_FLUSH, 16'($urandom()), 1'($urandom()));
      wait_idle();
    end

    // drain anything left open
    for (int k = 0; k <= sb.pending_frames; k++)
      send_item(ACT_FLUSH, 16'($urandom()), 1'($urandom()));
    wait_idle();

    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/drc_pkg.sv
design/drc_ram.sv
design/delta_regression_coefficients_top.sv
tb/sv/tb_delta_regression_coefficients_top.sv
